// ----- rtl/tac_pkg.sv -----
package tac_pkg;

    localparam int CH_BITS   = 8;
    localparam int CH_MAX    = (1 << CH_BITS) - 1;
    localparam int Q_BITS    = CH_BITS + 1;
    localparam int DIV_STEPS = Q_BITS;
    localparam int BLEND_LAT = 3 + DIV_STEPS + 1;
    localparam int TINT_LAT  = 2;

    typedef logic [CH_BITS-1:0]   t_ch;
    typedef logic [3:0][CH_BITS-1:0] t_pix;

    localparam logic [0:0] REG_TINT = 1'b0;
    localparam logic [0:0] REG_BACK = 1'b1;

    // floor(x / 255) for x below 2^16: estimate, then one correction
    function automatic t_ch div255(input logic [16:0] x);
        logic [8:0]  q;
        logic [17:0] r;
        logic [16:0] s;
        s = x + {8'd0, x[16:8]};
        q = s[16:8];
        r = {1'b0, x} - ({1'b0, q, 8'd0} - {9'd0, q});
        if (r >= 18'd255) begin
            q = q + 9'd1;
        end
        return q[7:0];
    endfunction

endpackage

// ----- rtl/tinted_alpha_composite_core.sv -----
// Tinted over-blend, one pixel word per clock. A word is taken whenever
// i_start is high (o_busy is always low) and its result appears for one cycle
// with o_valid after the tint pipe, then two blend pipes whose length is set
// by the 9-step restoring divider, then the output register. The receiver
// cannot stall; results must be taken as they come. Write tint and backdrop
// only while no word is in flight.
module tinted_alpha_composite_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    input  logic [7:0] i_dst_alpha,
    output logic       o_valid,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);
    import tac_pkg::*;

    logic [31:0] r_tint;
    logic [31:0] r_back;

    t_pix w_src, w_dst, w_tint, w_back;
    logic w_tv;
    t_pix w_tsrc, w_tdst;
    logic w_mv;
    t_pix w_mid;
    logic w_rv;
    t_pix w_res;

    t_pix r_dst_dly [1:BLEND_LAT];
    t_pix r_mid_dly [1:BLEND_LAT];
    logic r_op_dly  [1:BLEND_LAT];

    logic r_ov;
    t_pix r_opix;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint <= 32'hFFFF_FFFF;
            r_back <= 32'h0000_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TINT: r_tint <= i_cfg_data;
                REG_BACK: r_back <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_src  = {i_src_alpha, i_src_blue, i_src_green, i_src_red};
    assign w_dst  = {i_dst_alpha, i_dst_blue, i_dst_green, i_dst_red};
    assign w_tint = {r_tint[7:0], r_tint[15:8], r_tint[23:16], r_tint[31:24]};
    assign w_back = {r_back[7:0], r_back[15:8], r_back[23:16], r_back[31:24]};

    tac_tint u_tint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_src   (w_src),
        .i_dst   (w_dst),
        .i_tint  (w_tint),
        .o_valid (w_tv),
        .o_src   (w_tsrc),
        .o_dst   (w_tdst)
    );

    tac_blend u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tv),
        .i_fg    (w_tsrc),
        .i_bg    (w_back),
        .o_valid (w_mv),
        .o_pix   (w_mid)
    );

    // hold destination alongside the backdrop blend
    always_ff @(posedge i_clk) begin
        r_dst_dly[1] <= w_tdst;
        for (int i = 2; i <= BLEND_LAT; i++) begin
            r_dst_dly[i] <= r_dst_dly[i-1];
        end
    end

    tac_blend u_dest (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mv),
        .i_fg    (w_mid),
        .i_bg    (r_dst_dly[BLEND_LAT]),
        .o_valid (w_rv),
        .o_pix   (w_res)
    );

    // hold the intermediate and its opacity for the final pick
    always_ff @(posedge i_clk) begin
        r_mid_dly[1] <= w_mid;
        r_op_dly[1]  <= (w_mid[3] == 8'd255);
        for (int i = 2; i <= BLEND_LAT; i++) begin
            r_mid_dly[i] <= r_mid_dly[i-1];
            r_op_dly[i]  <= r_op_dly[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= w_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opix <= r_op_dly[BLEND_LAT] ? r_mid_dly[BLEND_LAT] : w_res;
    end

    assign o_valid     = r_ov;
    assign o_out_red   = r_opix[0];
    assign o_out_green = r_opix[1];
    assign o_out_blue  = r_opix[2];
    assign o_out_alpha = r_opix[3];
endmodule

// ----- rtl/tac_tint.sv -----
module tac_tint (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tac_pkg::t_pix i_src,
    input  tac_pkg::t_pix i_dst,
    input  tac_pkg::t_pix i_tint,
    output logic          o_valid,
    output tac_pkg::t_pix o_src,
    output tac_pkg::t_pix o_dst
);
    import tac_pkg::*;

    logic             r_v1;
    logic [3:0][15:0] r_prod;
    t_pix             r_dst1;
    logic             r_v2;
    t_pix             r_src2;
    t_pix             r_dst2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_prod[i] <= 16'(i_src[i] * i_tint[i]);
            r_src2[i] <= div255({1'b0, r_prod[i]} + 17'd127);
        end
        r_dst1 <= i_dst;
        r_dst2 <= r_dst1;
    end

    assign o_valid = r_v2;
    assign o_src   = r_src2;
    assign o_dst   = r_dst2;
endmodule

// ----- rtl/tac_blend.sv -----
module tac_blend (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tac_pkg::t_pix i_fg,
    input  tac_pkg::t_pix i_bg,
    output logic          o_valid,
    output tac_pkg::t_pix o_pix
);
    import tac_pkg::*;

    // product stage
    logic             r1_v;
    logic [2:0][15:0] r1_p;
    logic [2:0][15:0] r1_q;
    logic [15:0]      r1_ba;
    t_ch              r1_af;
    t_pix             r1_bg;
    logic             r1_abop;

    // denominator stage
    logic             r2_v;
    logic [15:0]      r2_den;
    logic [2:0][23:0] r2_bba;
    logic [2:0][15:0] r2_p;
    logic [2:0][7:0]  r2_opq;
    logic             r2_abop;

    // numerator stage
    logic             r3_v;
    logic [2:0][23:0] r3_num;
    logic [15:0]      r3_den;
    t_ch              r3_alpha;
    logic [2:0][7:0]  r3_opq;
    logic             r3_abop;
    logic             r3_zero;

    // divider stages, one quotient bit each
    logic             r_dv    [1:DIV_STEPS];
    logic [15:0]      r_dden  [1:DIV_STEPS];
    logic [2:0][15:0] r_drem  [1:DIV_STEPS];
    logic [2:0][8:0]  r_dlow  [1:DIV_STEPS];
    logic [2:0][8:0]  r_dq    [1:DIV_STEPS];
    t_ch              r_dalpha[1:DIV_STEPS];
    logic [2:0][7:0]  r_dopq  [1:DIV_STEPS];
    logic             r_dabop [1:DIV_STEPS];
    logic             r_dzero [1:DIV_STEPS];

    logic r_ov;
    t_pix r_opix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_p[i] <= 16'(i_fg[i] * i_fg[3]);
            r1_q[i] <= 16'(i_bg[i] * (8'd255 - i_fg[3]));
        end
        r1_ba   <= 16'(i_bg[3] * (8'd255 - i_fg[3]));
        r1_af   <= i_fg[3];
        r1_bg   <= i_bg;
        r1_abop <= (i_bg[3] == 8'd255);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_bba[i] <= 24'(r1_bg[i] * r1_ba);
            r2_opq[i] <= div255({1'b0, r1_p[i]} + {1'b0, r1_q[i]} + 17'd127);
        end
        r2_den  <= 16'({r1_af, 8'd0} - {8'd0, r1_af} + r1_ba);
        r2_p    <= r1_p;
        r2_abop <= r1_abop;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_num[i] <= {r2_p[i], 8'd0} - {8'd0, r2_p[i]} + r2_bba[i]
                         + {9'd0, r2_den[15:1]};
        end
        r3_den   <= r2_den;
        r3_alpha <= div255({1'b0, r2_den} + 17'd127);
        r3_opq   <= r2_opq;
        r3_abop  <= r2_abop;
        r3_zero  <= (r2_den == 16'd0);
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic             w_v;
        logic [15:0]      w_den;
        logic [2:0][15:0] w_rem;
        logic [2:0][8:0]  w_low;
        logic [2:0][8:0]  w_q;
        t_ch              w_alpha;
        logic [2:0][7:0]  w_opq;
        logic             w_abop;
        logic             w_zero;

        if (k == 1) begin : g_first
            always_comb begin
                w_v     = r3_v;
                w_den   = r3_den;
                w_alpha = r3_alpha;
                w_opq   = r3_opq;
                w_abop  = r3_abop;
                w_zero  = r3_zero;
                for (int i = 0; i < 3; i++) begin
                    w_rem[i] = {1'b0, r3_num[i][23:9]};
                    w_low[i] = r3_num[i][8:0];
                    w_q[i]   = 9'd0;
                end
            end
        end else begin : g_next
            always_comb begin
                w_v     = r_dv[k-1];
                w_den   = r_dden[k-1];
                w_rem   = r_drem[k-1];
                w_low   = r_dlow[k-1];
                w_q     = r_dq[k-1];
                w_alpha = r_dalpha[k-1];
                w_opq   = r_dopq[k-1];
                w_abop  = r_dabop[k-1];
                w_zero  = r_dzero[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else begin
                r_dv[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            logic [16:0] t;
            logic        ge;
            for (int i = 0; i < 3; i++) begin
                t  = {w_rem[i], w_low[i][8]};
                ge = (t >= {1'b0, w_den});
                r_drem[k][i] <= ge ? 16'(t - {1'b0, w_den}) : t[15:0];
                r_dlow[k][i] <= {w_low[i][7:0], 1'b0};
                r_dq[k][i]   <= {w_q[i][7:0], ge};
            end
            r_dden[k]   <= w_den;
            r_dalpha[k] <= w_alpha;
            r_dopq[k]   <= w_opq;
            r_dabop[k]  <= w_abop;
            r_dzero[k]  <= w_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_dv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dabop[DIV_STEPS]) begin
            for (int i = 0; i < 3; i++) begin
                r_opix[i] <= r_dopq[DIV_STEPS][i];
            end
            r_opix[3] <= 8'd255;
        end else if (r_dzero[DIV_STEPS]) begin
            r_opix <= '0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                // clamp
                r_opix[i] <= r_dq[DIV_STEPS][i][8] ? 8'd255 : r_dq[DIV_STEPS][i][7:0];
            end
            r_opix[3] <= r_dalpha[DIV_STEPS];
        end
    end

    assign o_valid = r_ov;
    assign o_pix   = r_opix;
endmodule

// ----- sim/tb.sv -----
module tb;
    import tac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT  = 29;
    localparam int WDOG_MAX  = 2000;
    localparam int N_PHASES  = 6;
    localparam int PHASE_LEN = 90;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic [7:0]  i_src_red, i_src_green, i_src_blue, i_src_alpha;
    logic [7:0]  i_dst_red, i_dst_green, i_dst_blue, i_dst_alpha;
    logic        o_valid;
    logic [7:0]  o_out_red, o_out_green, o_out_blue, o_out_alpha;

    tinted_alpha_composite_core dut (.*);

    typedef struct {
        logic [31:0] src;
        logic [31:0] dst;
        bit          typed;
        logic [31:0] want;
    } t_row;

    // packed red 31:24, green 23:16, blue 15:8, alpha 7:0
    logic [31:0] tint_reg;
    logic [31:0] back_reg;
    logic [31:0] pixel_q[$];
    int          errors;
    int          quiet_cycles;
    int          idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int chan(input logic [31:0] p, input int i);
        return int'(p[31-8*i -: 8]);
    endfunction

    function automatic logic [31:0] over(input logic [31:0] fg, input logic [31:0] bg);
        int af, ab, inv, ba, den, v;
        logic [31:0] r;
        af  = chan(fg, 3);
        ab  = chan(bg, 3);
        inv = CH_MAX - af;
        r   = '0;
        if (ab == CH_MAX) begin
            for (int i = 0; i < 3; i++)
                r[31-8*i -: 8] = 8'((chan(fg, i) * af + chan(bg, i) * inv
                                     + CH_MAX / 2) / CH_MAX);
            r[7:0] = 8'(CH_MAX);
            return r;
        end
        ba  = ab * inv;
        den = af * CH_MAX + ba;
        if (den == 0)
            return '0;
        for (int i = 0; i < 3; i++) begin
            v = (chan(fg, i) * af * CH_MAX + chan(bg, i) * ba + den / 2) / den;
            r[31-8*i -: 8] = 8'((v > CH_MAX) ? CH_MAX : v);
        end
        v = (den + CH_MAX / 2) / CH_MAX;
        r[7:0] = 8'((v > CH_MAX) ? CH_MAX : v);
        return r;
    endfunction

    function automatic logic [31:0] composite(input logic [31:0] src, input logic [31:0] dst);
        logic [31:0] tinted, mid;
        for (int i = 0; i < 4; i++)
            tinted[31-8*i -: 8] = 8'((chan(src, i) * chan(tint_reg, i) + CH_MAX / 2)
                                     / CH_MAX);
        mid = over(tinted, back_reg);
        if (mid[7:0] == CH_MAX)
            return mid;
        return over(mid, dst);
    endfunction

    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 7))
                0:       p[8*i +: 8] = 8'h00;
                1:       p[8*i +: 8] = 8'hff;
                2:       p[8*i +: 8] = 8'hfe;
                default: p[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    // result monitor; outputs sampled before the edge updates them
    always @(posedge i_clk) begin
        logic [31:0] got, exp_pix;
        got = {o_out_red, o_out_green, o_out_blue, o_out_alpha};
        if (i_rst_n && o_valid) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
            end else begin
                exp_pix = pixel_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (got[31-8*i -: 8] !== exp_pix[31-8*i -: 8]) begin
                        $display("%0t: channel %0d expected %h actual %h (pixel %h / %h)",
                                 $time, i, exp_pix[31-8*i -: 8], got[31-8*i -: 8],
                                 exp_pix, got);
                        errors++;
                    end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (i_start && !o_busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // drive one word and hold it until taken; leaves i_start high
    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst,
                              input bit typed, input logic [31:0] want);
        logic [31:0] pred;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start     <= 1'b1;
        {i_src_red, i_src_green, i_src_blue, i_src_alpha} <= src;
        {i_dst_red, i_dst_green, i_dst_blue, i_dst_alpha} <= dst;
        @(posedge i_clk iff !o_busy);
        pred = composite(src, dst);
        if (typed && pred !== want) begin
            $display("%0t: table row expected %h predicted %h", $time, want, pred);
            errors++;
        end
        pixel_q.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 3) @(posedge i_clk);
    endtask

    // write tint, then backdrop, on consecutive edges
    task automatic write_regs(input logic [31:0] tint, input logic [31:0] back);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TINT;
        i_cfg_data <= tint;
        @(posedge i_clk);
        i_cfg_idx  <= REG_BACK;
        i_cfg_data <= back;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tint_reg = tint;
        back_reg = back;
    endtask

    t_row dir_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'hffff_ffff, 32'h0000_0000, 1'b1, 32'hffff_ffff},
        '{32'hffff_ffff, 32'h1234_5678, 1'b1, 32'hffff_ffff},
        '{32'h0000_0000, 32'h1234_56ff, 1'b1, 32'h1234_56ff},
        '{32'hffff_ff00, 32'habcd_efff, 1'b1, 32'habcd_efff},
        '{32'h0000_0000, 32'hffff_ff00, 1'b1, 32'h0000_0000},
        '{32'h0000_00ff, 32'hffff_ffff, 1'b1, 32'h0000_00ff},
        '{32'h8080_8080, 32'h4040_4040, 1'b0, 32'h0},
        '{32'hff00_ff80, 32'h00ff_00ff, 1'b0, 32'h0},
        '{32'h0102_0301, 32'hfefd_fc01, 1'b0, 32'h0},
        '{32'h5555_55fe, 32'haaaa_aa80, 1'b0, 32'h0},
        '{32'haaaa_aa01, 32'h5555_55fe, 1'b0, 32'h0},
        '{32'hffff_ff7f, 32'h0000_0080, 1'b0, 32'h0},
        '{32'h1020_30fe, 32'hffff_ff01, 1'b0, 32'h0},
        '{32'hfefe_fefe, 32'h0101_0101, 1'b0, 32'h0},
        '{32'h7f80_7f80, 32'h807f_807f, 1'b0, 32'h0}
    };

    initial begin
        logic [31:0] tints[N_PHASES], backs[N_PHASES];
        int          idles[4] = '{0, 49, 0, 25};
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_TINT;
        i_cfg_data = '0;
        {i_src_red, i_src_green, i_src_blue, i_src_alpha} = '0;
        {i_dst_red, i_dst_green, i_dst_blue, i_dst_alpha} = '0;
        tint_reg     = 32'hffff_ffff;
        back_reg     = 32'h0000_0000;
        errors       = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_pixel(dir_rows[k].src, dir_rows[k].dst, dir_rows[k].typed, dir_rows[k].want);
        drain();

        tints = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ff80, 32'h80ff_40fe,
                  $urandom(), $urandom()};
        backs = '{32'hffff_ffff, 32'h1020_3080, 32'h0000_0000, 32'hff00_ff01,
                  $urandom(), {24'($urandom_range(0, 32'hffffff)), 8'hfe}};
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_regs(tints[ph], backs[ph]);
            idle_pct = idles[ph % 4];
            for (int n = 0; n < PHASE_LEN; n++)
                send_pixel(rand_pixel(), rand_pixel(), 1'b0, 32'h0);
            drain();
        end

        if (errors == 0 && pixel_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (pixel_q.size() != 0)
                $display("%0t: %0d words never arrived", $time, pixel_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
